### src/edd_pkg.sv
// Shared types, constants and arithmetic for the error-diffusion dither.
// Used by every design module of the block; depends on nothing.
package edd_pkg;

    // Row buffer size and derived widths
    localparam int MAX_LINE_WIDTH = 1024;
    localparam int COL_W          = $clog2(MAX_LINE_WIDTH);
    localparam int LINE_W_W       = 11;
    localparam int ROW_W          = 16;
    localparam int CFG_DATA_W     = 16;
    localparam int CMP_W          = (COL_W + 1 > LINE_W_W) ? COL_W + 1 : LINE_W_W;

    // Decoupling queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Configuration register indexes
    localparam logic [0:0] REG_LINE_WIDTH   = 1'b0;
    localparam logic [0:0] REG_FRAME_HEIGHT = 1'b1;

    // Configuration reset values
    localparam logic [LINE_W_W-1:0] LINE_WIDTH_RESET   = 11'd640;
    localparam logic [ROW_W-1:0]    FRAME_HEIGHT_RESET = 16'd480;

    // Luma weights in 0.16 fixed point, plus rounding half
    localparam logic [24:0] GRAY_R_COEF = 25'd19595;
    localparam logic [24:0] GRAY_G_COEF = 25'd38470;
    localparam logic [24:0] GRAY_B_COEF = 25'd7471;
    localparam logic [24:0] GRAY_ROUND  = 25'd32768;

    // One classified pixel, as it travels from front to back
    typedef struct packed {
        logic [7:0]       gray;
        logic [COL_W-1:0] col;
        logic             has_above;
        logic             has_left;
        logic             eof;
    } edd_item_t;

    // Add 2/8 or 3/8 of an error to a level, round half up, clamp to 0..255
    function automatic logic [7:0] add_share(
        input logic [7:0]        level,
        input logic signed [7:0] err,
        input logic              k_is_three
    );
        logic signed [12:0] scaled;
        logic signed [12:0] sum;
        scaled = k_is_three ? ((13'(err) <<< 1) + 13'(err)) : (13'(err) <<< 1);
        sum    = $signed({2'b00, level, 3'b000}) + scaled + 13'sd4;
        if (sum[12])
            add_share = 8'd0;
        else if (sum[11])
            add_share = 8'hFF;
        else
            add_share = sum[10:3];
    endfunction

endpackage

### src/error_diffusion_dither.sv
// Top level of the error-diffusion dither: ties front, queue and back.
// Depends on edd_pkg, edd_front, edd_queue and edd_back.
//
// RGB pixels enter in raster order and leave as one black/white bit each,
// at a sustained rate of one pixel per clock while results are taken; once
// a pixel of an idle block is accepted, its result passes through gray
// conversion on the way into the queue, then queue to buffer read,
// diagonal/above diffusion and left diffusion into the result register.
// The rate is set by the left-error feedback, which closes within the
// final back stage, and by the row error buffer, with one read port and
// one write port, each used once per pixel. The queue of four entries lets
// intake continue while a result waits to be taken. Registers: index 0 is
// line_width (1..1024 pixels, reset 640), index 1 is frame_height (reset
// 480 rows); change them only while no pixel is in flight. The row buffer
// needs no clearing: the first row of a frame ignores it.
module error_diffusion_dither (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [0:0]                      cfg_index,
    input  logic [edd_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            pix_valid,
    output logic                            pix_ready,
    input  logic [7:0]                      red,
    input  logic [7:0]                      green,
    input  logic [7:0]                      blue,
    output logic                            res_valid,
    input  logic                            res_ready,
    output logic                            white,
    output logic                            end_of_frame
);

    edd_pkg::edd_item_t push_item;
    edd_pkg::edd_item_t pop_item;
    logic               q_push;
    logic               q_pop;
    logic               q_full;
    logic               q_empty;

    // Intake and classification
    edd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pix_valid (pix_valid),
        .pix_ready (pix_ready),
        .red       (red),
        .green     (green),
        .blue      (blue),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_item    (push_item)
    );

    // Decoupling queue
    edd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .pop_item  (pop_item),
        .empty     (q_empty)
    );

    // Diffusion and result
    edd_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_item       (pop_item),
        .q_empty      (q_empty),
        .q_pop        (q_pop),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .white        (white),
        .end_of_frame (end_of_frame)
    );

endmodule

### src/edd_front.sv
// Front part of the dither: configuration registers, pixel intake, gray
// conversion and row/column tracking. Depends on edd_pkg.
module edd_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [0:0]                      cfg_index,
    input  logic [edd_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            pix_valid,
    output logic                            pix_ready,
    input  logic [7:0]                      red,
    input  logic [7:0]                      green,
    input  logic [7:0]                      blue,
    input  logic                            q_full,
    output logic                            q_push,
    output edd_pkg::edd_item_t              q_item
);

    logic [edd_pkg::LINE_W_W-1:0] line_width_reg;
    logic [edd_pkg::ROW_W-1:0]    frame_height_reg;
    logic [edd_pkg::COL_W-1:0]    col_reg;
    logic [edd_pkg::COL_W-1:0]    col_next;
    logic [edd_pkg::ROW_W-1:0]    row_reg;
    logic [edd_pkg::ROW_W-1:0]    row_next;
    logic [edd_pkg::COL_W:0]      col_plus;
    logic [edd_pkg::ROW_W:0]      row_plus;
    logic                         last_col;
    logic                         last_row;
    logic [24:0]                  gray_sum;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_width_reg   <= edd_pkg::LINE_WIDTH_RESET;
            frame_height_reg <= edd_pkg::FRAME_HEIGHT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                edd_pkg::REG_LINE_WIDTH:
                    line_width_reg <= cfg_data[edd_pkg::LINE_W_W-1:0];
                edd_pkg::REG_FRAME_HEIGHT:
                    frame_height_reg <= cfg_data[edd_pkg::ROW_W-1:0];
            endcase
        end
    end

    // Accept while the queue has room
    assign pix_ready = !q_full;
    assign q_push    = pix_valid && pix_ready;

    // Detect row and frame ends; width zero acts as one, wide rows clamp to the buffer
    assign col_plus = {1'b0, col_reg} + 1'b1;
    assign row_plus = {1'b0, row_reg} + 1'b1;
    assign last_col = (edd_pkg::CMP_W'(col_plus) >= edd_pkg::CMP_W'(line_width_reg))
                   || (col_reg == edd_pkg::COL_W'(edd_pkg::MAX_LINE_WIDTH - 1));
    assign last_row = row_plus >= {1'b0, frame_height_reg};

    // Advance position counters
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (q_push)
        begin
            if (last_col)
            begin
                col_next = '0;
                row_next = last_row ? '0 : row_plus[edd_pkg::ROW_W-1:0];
            end
            else
            begin
                col_next = col_plus[edd_pkg::COL_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // Convert to gray with rounding
    assign gray_sum = edd_pkg::GRAY_R_COEF * 25'(red)
                    + edd_pkg::GRAY_G_COEF * 25'(green)
                    + edd_pkg::GRAY_B_COEF * 25'(blue)
                    + edd_pkg::GRAY_ROUND;

    // Classify the request for the back part
    always_comb
    begin
        q_item.gray      = gray_sum[23:16];
        q_item.col       = col_reg;
        q_item.has_above = row_reg != '0;
        q_item.has_left  = col_reg != '0;
        q_item.eof       = last_col && last_row;
    end

endmodule

### src/edd_queue.sv
// Short first-in first-out queue of classified pixels between front and back.
// Depends on edd_pkg for the entry type and depth.
module edd_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  edd_pkg::edd_item_t push_item,
    output logic               full,
    input  logic               pop,
    output edd_pkg::edd_item_t pop_item,
    output logic               empty
);

    edd_pkg::edd_item_t          entry_reg [edd_pkg::QUEUE_DEPTH];
    logic [edd_pkg::QPTR_W-1:0]  wr_ptr_reg;
    logic [edd_pkg::QPTR_W-1:0]  rd_ptr_reg;
    logic [edd_pkg::QPTR_W:0]    count_reg;
    logic [edd_pkg::QPTR_W:0]    count_next;

    assign full     = count_reg == (edd_pkg::QPTR_W + 1)'(edd_pkg::QUEUE_DEPTH);
    assign empty    = count_reg == '0;
    assign pop_item = entry_reg[rd_ptr_reg];

    // Track fill level
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    // Advance pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    // Store entries
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_item;
    end

endmodule

### src/edd_back.sv
// Back part of the dither: row error buffer, error diffusion in two stages,
// quantization and the result register. Depends on edd_pkg.
module edd_back (
    input  logic               clk,
    input  logic               rst_n,
    input  edd_pkg::edd_item_t q_item,
    input  logic               q_empty,
    output logic               q_pop,
    output logic               res_valid,
    input  logic               res_ready,
    output logic               white,
    output logic               end_of_frame
);

    // Row error buffer
    logic signed [7:0]            err_mem [edd_pkg::MAX_LINE_WIDTH];
    logic signed [7:0]            rdata_reg;

    // Stage one: item and buffer read
    logic                         s1_valid_reg;
    edd_pkg::edd_item_t           s1_item_reg;
    logic signed [7:0]            diag_reg;
    logic signed [7:0]            above_raw;
    logic signed [7:0]            above;
    logic [7:0]                   v1;
    logic [7:0]                   v2;

    // Stage two: left error and quantization
    logic                         s2_valid_reg;
    logic [7:0]                   s2_level_reg;
    logic [edd_pkg::COL_W-1:0]    s2_col_reg;
    logic                         s2_has_left_reg;
    logic                         s2_eof_reg;
    logic signed [7:0]            left_reg;
    logic [7:0]                   v3;
    logic                         s2_white;
    logic signed [7:0]            s2_err;

    // Last buffer write, for a read that raced it
    logic                         wb_valid_reg;
    logic [edd_pkg::COL_W-1:0]    wb_col_reg;
    logic signed [7:0]            wb_err_reg;

    // Result register
    logic                         out_valid_reg;
    logic                         white_reg;
    logic                         eof_reg;

    logic                         advance;

    // Move the whole back pipeline unless a result is held
    assign advance = !out_valid_reg || res_ready;
    assign q_pop   = advance && !q_empty;

    // Pick the newest error of the pixel above
    always_comb
    begin
        if (s2_valid_reg && s2_col_reg == s1_item_reg.col)
            above_raw = s2_err;
        else if (wb_valid_reg && wb_col_reg == s1_item_reg.col)
            above_raw = wb_err_reg;
        else
            above_raw = rdata_reg;
        above = s1_item_reg.has_above ? above_raw : 8'sd0;
    end

    // Add diagonal then above shares
    always_comb
    begin
        v1 = s1_item_reg.gray;
        if (s1_item_reg.has_above && s1_item_reg.has_left)
            v1 = edd_pkg::add_share(s1_item_reg.gray, diag_reg, 1'b0);
        v2 = v1;
        if (s1_item_reg.has_above)
            v2 = edd_pkg::add_share(v1, above, 1'b1);
    end

    // Add left share and quantize
    always_comb
    begin
        v3 = s2_has_left_reg ? edd_pkg::add_share(s2_level_reg, left_reg, 1'b1)
                             : s2_level_reg;
        s2_white = v3[7];
        s2_err   = $signed(v3 + {7'd0, s2_white});
    end

    // Control of stage valids, feedback errors and the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            wb_valid_reg  <= 1'b0;
            diag_reg      <= 8'sd0;
            left_reg      <= 8'sd0;
        end
        else if (advance)
        begin
            s1_valid_reg  <= q_pop;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg;
            if (s1_valid_reg)
                diag_reg <= above;
            if (s2_valid_reg)
            begin
                left_reg     <= s2_err;
                wb_valid_reg <= 1'b1;
            end
        end
    end

    // Payload of the stages
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            if (q_pop)
                s1_item_reg <= q_item;
            if (s1_valid_reg)
            begin
                s2_level_reg    <= v2;
                s2_col_reg      <= s1_item_reg.col;
                s2_has_left_reg <= s1_item_reg.has_left;
                s2_eof_reg      <= s1_item_reg.eof;
            end
            if (s2_valid_reg)
            begin
                wb_col_reg <= s2_col_reg;
                wb_err_reg <= s2_err;
                white_reg  <= s2_white;
                eof_reg    <= s2_eof_reg;
            end
        end
    end

    // Read and write the row error buffer
    always_ff @(posedge clk)
    begin
        if (q_pop)
            rdata_reg <= err_mem[q_item.col];
        if (advance && s2_valid_reg)
            err_mem[s2_col_reg] <= s2_err;
    end

    assign res_valid    = out_valid_reg;
    assign white        = white_reg;
    assign end_of_frame = eof_reg;

endmodule

### src/edd_port_check.sv
// Port-level checks of the dither's handshakes and request accounting.
// Bound to error_diffusion_dither; depends on nothing else.
module edd_port_check (
    input  logic clk,
    input  logic rst_n,
    input  logic pix_valid,
    input  logic pix_ready,
    input  logic res_valid,
    input  logic res_ready,
    input  logic white,
    input  logic end_of_frame
);

    logic [3:0] pending_reg;
    logic       pix_take;
    logic       res_take;

    assign pix_take = pix_valid && pix_ready;
    assign res_take = res_valid && res_ready;

    // Count requests accepted but not yet answered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pending_reg <= '0;
        else if (pix_take && !res_take)
            pending_reg <= pending_reg + 1'b1;
        else if (res_take && !pix_take)
            pending_reg <= pending_reg - 1'b1;
    end

    // Hold a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result dropped while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> $stable(white) && $stable(end_of_frame))
        else $error("result changed while stalled");

    // Never answer without a pending request
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> pending_reg != '0)
        else $error("result without a request");

    // Refuse intake only with work in flight
    assert property (@(posedge clk) disable iff (!rst_n)
        !pix_ready |-> pending_reg != '0)
        else $error("intake stalled while empty");

    // Keep results quiet once reset has been seen
    assert property (@(posedge clk)
        !rst_n |=> !res_valid)
        else $error("result valid during reset");

endmodule

bind error_diffusion_dither edd_port_check u_port_check (.*);
